### hdl/wrsi_pkg.sv
// Shared types and constants for the Wilder RSI stream block.
package wrsi_pkg;
   localparam int AVG_BITS = 56;
   localparam int PROD_BITS = 64;
   localparam int RSI_BITS = 15;
   localparam int WIN_BITS = 8;
   localparam int SUM_LIMIT_BIT = 49;
   localparam logic [RSI_BITS-1:0] RSI_HALF = 15'd12800;
   localparam logic [RSI_BITS-1:0] RSI_FULL = 15'd25600;

   typedef enum logic [1:0] {
      OP_RESTART = 2'd0,
      OP_WARM    = 2'd1,
      OP_SMOOTH  = 2'd2
   } op_type;
endpackage

### hdl/wrsi_if.sv
// Valid/ready channel interface carrying a generic payload.
interface wrsi_if #(parameter int WIDTH = 8) (input logic clock);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hdl/wilder_rsi_stream.sv
// Top level of the Wilder RSI stream block.
// Warm-up items answer from idle; the end of warm-up divides the sums; smoothing multiplies,
// divides, and for a nonzero loss average normalizes (no shift at default sizes) and divides.
// Throughput: the back stage runs one transaction at a time and its serial 64-bit divider
// sets the rate; a one-entry queue in the front holds the next transaction meanwhile.
// Reset: synchronous, active high; window returns to 14 and all series state clears.
module wilder_rsi_stream #(
   parameter int PRICE_BITS = 32,
   parameter int WINDOW_MAX = 255
) (
   input logic clock,
   input logic reset,
   wrsi_if.sink   req,
   wrsi_if.source rsp,
   wrsi_if.sink   csr
);
   localparam int CNT_BITS = $clog2(WINDOW_MAX + 2);
   logic [wrsi_pkg::WIN_BITS-1:0] window_ff;
   logic cmd_valid, cmd_ready, cmd_div;
   wrsi_pkg::op_type cmd_op;
   logic [PRICE_BITS-1:0] cmd_up, cmd_down;
   logic [CNT_BITS-1:0] cmd_win;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) window_ff <= wrsi_pkg::WIN_BITS'(14);
      else if (csr.valid) window_ff <= csr.data[wrsi_pkg::WIN_BITS-1:0];
   end

   wrsi_front #(.PRICE_BITS(PRICE_BITS), .WINDOW_MAX(WINDOW_MAX), .CNT_BITS(CNT_BITS)) u_front (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .req_price(req.data[PRICE_BITS:1]), .req_series_start(req.data[0]),
      .window_ff_i(window_ff),
      .cmd_valid, .cmd_ready, .cmd_op, .cmd_div, .cmd_up, .cmd_down, .cmd_win
   );

   wrsi_back #(.PRICE_BITS(PRICE_BITS), .CNT_BITS(CNT_BITS)) u_back (
      .clock, .reset,
      .cmd_valid, .cmd_ready, .cmd_op, .cmd_div, .cmd_up, .cmd_down, .cmd_win,
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_rsi_value(rsp.data[15:1]), .rsp_warming_up(rsp.data[0])
   );
endmodule

### hdl/wrsi_front.sv
// Front stage: takes price transactions, classifies them, tracks counts and differences.
module wrsi_front #(
   parameter int PRICE_BITS = 32,
   parameter int WINDOW_MAX = 255,
   parameter int CNT_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [PRICE_BITS-1:0]         req_price,
   input  logic                          req_series_start,
   input  logic [wrsi_pkg::WIN_BITS-1:0] window_ff_i,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output wrsi_pkg::op_type              cmd_op,
   output logic                          cmd_div,
   output logic [PRICE_BITS-1:0]         cmd_up,
   output logic [PRICE_BITS-1:0]         cmd_down,
   output logic [CNT_BITS-1:0]           cmd_win
);
   logic [PRICE_BITS-1:0] last_ff;
   logic [CNT_BITS-1:0]   count_ff, count_in, win;
   logic                  take;
   logic                  cmd_valid_ff, cmd_valid_in;
   wrsi_pkg::op_type      op_ff, op_in;
   logic                  div_ff, div_in;
   logic [PRICE_BITS-1:0] up_ff, up_in, down_ff, down_in;
   logic [CNT_BITS-1:0]   win_ff;

   always_comb begin
      win = CNT_BITS'(window_ff_i);
      if (win == '0) win = CNT_BITS'(1);
      if (win > CNT_BITS'(WINDOW_MAX)) win = CNT_BITS'(WINDOW_MAX);
   end

   assign req_ready = !cmd_valid_ff || cmd_ready;
   assign take = req_valid && req_ready;
   assign cmd_valid_in = take || (cmd_valid_ff && !cmd_ready);
   assign up_in = (req_price > last_ff) ? req_price - last_ff : '0;
   assign down_in = (req_price > last_ff) ? '0 : last_ff - req_price;

   assign cmd_valid = cmd_valid_ff;
   assign cmd_op = op_ff;
   assign cmd_div = div_ff;
   assign cmd_up = up_ff;
   assign cmd_down = down_ff;
   assign cmd_win = win_ff;

   always_comb begin
      div_in = 1'b0;
      count_in = count_ff;
      if (req_series_start || count_ff == '0) begin
         op_in = wrsi_pkg::OP_RESTART;
         count_in = CNT_BITS'(1);
      end else if (count_ff <= win) begin
         op_in = wrsi_pkg::OP_WARM;
         div_in = (count_ff == win);
         count_in = count_ff + CNT_BITS'(1);
      end else begin
         op_in = wrsi_pkg::OP_SMOOTH;
         count_in = win + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         last_ff <= '0;
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         if (take) begin
            count_ff <= count_in;
            last_ff <= req_price;
            op_ff <= op_in;
            div_ff <= div_in;
            up_ff <= up_in;
            down_ff <= down_in;
            win_ff <= win;
         end
      end
   end
endmodule

### hdl/wrsi_back.sv
// Back stage: sequential averaging, smoothing and RSI division with a serial divider.
module wrsi_back #(
   parameter int PRICE_BITS = 32,
   parameter int CNT_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  wrsi_pkg::op_type                  cmd_op,
   input  logic                              cmd_div,
   input  logic [PRICE_BITS-1:0]             cmd_up,
   input  logic [PRICE_BITS-1:0]             cmd_down,
   input  logic [CNT_BITS-1:0]               cmd_win,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [wrsi_pkg::RSI_BITS-1:0]     rsp_rsi_value,
   output logic                              rsp_warming_up
);
   localparam int PB = wrsi_pkg::PROD_BITS;
   localparam int AB = wrsi_pkg::AVG_BITS;
   localparam int STEP_BITS = 7;
   localparam int RB = PB + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_DIVG, S_DIVL, S_NORM, S_RSI, S_OUT
   } state_type;

   state_type              state_ff;
   logic [AB-1:0]          gain_ff, loss_ff;
   logic [PRICE_BITS-1:0]  up_ff, down_ff;
   logic [CNT_BITS-1:0]    win_ff;
   logic                   smooth_ff;
   logic [PB-1:0]          num_ff, den_ff;
   logic [RB-1:0]          rem_ff;
   logic [STEP_BITS-1:0]   step_ff;
   logic [AB-1:0]          g_ff, l_ff;
   logic [PB-1:0]          prod_g, prod_l;
   logic [RB-1:0]          rem_in;
   logic                   fits;
   logic [AB:0]            gl_sum;

   assign cmd_ready = (state_ff == S_IDLE) && !rsp_valid;
   assign rem_in = {rem_ff[RB-2:0], num_ff[PB-1]};
   assign fits = rem_in >= {1'b0, den_ff};
   assign prod_g = PB'(gain_ff) * PB'(win_ff - CNT_BITS'(1));
   assign prod_l = PB'(loss_ff) * PB'(win_ff - CNT_BITS'(1));
   assign gl_sum = {1'b0, g_ff} + {1'b0, l_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid <= 1'b0;
         gain_ff <= '0;
         loss_ff <= '0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  up_ff <= cmd_up;
                  down_ff <= cmd_down;
                  win_ff <= cmd_win;
                  rem_ff <= '0;
                  step_ff <= '0;
                  case (cmd_op)
                     wrsi_pkg::OP_RESTART: begin
                        gain_ff <= '0;
                        loss_ff <= '0;
                        rsp_rsi_value <= wrsi_pkg::RSI_HALF;
                        rsp_warming_up <= 1'b1;
                        rsp_valid <= 1'b1;
                     end
                     wrsi_pkg::OP_WARM: begin
                        gain_ff <= gain_ff + AB'(cmd_up);
                        loss_ff <= loss_ff + AB'(cmd_down);
                        rsp_rsi_value <= wrsi_pkg::RSI_HALF;
                        rsp_warming_up <= 1'b1;
                        smooth_ff <= 1'b0;
                        num_ff <= PB'(gain_ff + AB'(cmd_up));
                        den_ff <= PB'(cmd_win);
                        if (cmd_div) state_ff <= S_DIVG;
                        else rsp_valid <= 1'b1;
                     end
                     default: begin
                        smooth_ff <= 1'b1;
                        state_ff <= S_MUL;
                     end
                  endcase
               end
            end
            S_MUL: begin
               num_ff <= prod_g + PB'(up_ff);
               den_ff <= PB'(win_ff);
               state_ff <= S_DIVG;
            end
            S_DIVG, S_DIVL: begin
               if (step_ff == STEP_BITS'(PB - 1)) begin
                  rem_ff <= '0;
                  step_ff <= '0;
                  if (state_ff == S_DIVG) begin
                     gain_ff <= AB'({num_ff[PB-2:0], fits});
                     num_ff <= smooth_ff ? prod_l + PB'(down_ff) : PB'(loss_ff);
                     state_ff <= S_DIVL;
                  end else begin
                     loss_ff <= AB'({num_ff[PB-2:0], fits});
                     g_ff <= gain_ff;
                     l_ff <= AB'({num_ff[PB-2:0], fits});
                     if (smooth_ff) state_ff <= S_NORM;
                     else begin
                        rsp_valid <= 1'b1;
                        state_ff <= S_IDLE;
                     end
                  end
               end else begin
                  num_ff <= {num_ff[PB-2:0], fits};
                  rem_ff <= fits ? rem_in - {1'b0, den_ff} : rem_in;
                  step_ff <= step_ff + STEP_BITS'(1);
               end
            end
            S_NORM: begin
               if (l_ff == '0) begin
                  rsp_rsi_value <= wrsi_pkg::RSI_FULL;
                  rsp_warming_up <= 1'b0;
                  rsp_valid <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (gl_sum >= (AB+1)'(1) << wrsi_pkg::SUM_LIMIT_BIT) begin
                  g_ff <= g_ff >> 1;
                  l_ff <= l_ff >> 1;
               end else begin
                  num_ff <= PB'(g_ff) * PB'(wrsi_pkg::RSI_FULL);
                  den_ff <= PB'(gl_sum);
                  state_ff <= S_RSI;
               end
            end
            S_RSI: begin
               num_ff <= {num_ff[PB-2:0], fits};
               rem_ff <= fits ? rem_in - {1'b0, den_ff} : rem_in;
               step_ff <= step_ff + STEP_BITS'(1);
               if (step_ff == STEP_BITS'(PB - 1)) state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_rsi_value <= (num_ff > PB'(wrsi_pkg::RSI_FULL)) ? wrsi_pkg::RSI_FULL
                                : wrsi_pkg::RSI_BITS'(num_ff);
               rsp_warming_up <= 1'b0;
               rsp_valid <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !cmd_ready)
      else $error("command taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_rsi_value))
      else $error("result dropped");
   a_rsi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rsi_value <= wrsi_pkg::RSI_FULL)
      else $error("rsi out of range");
endmodule

### sim/wilder_rsi_stream_tb.sv
// Self-checking testbench for the Wilder RSI stream block.
`timescale 1ns / 100ps

module wilder_rsi_stream_tb;

   typedef struct packed {
      logic [wrsi_pkg::RSI_BITS-1:0] rsi_value;
      logic                          warming_up;
   } rsi_result_type;

   class rsi_scoreboard;
      logic [wrsi_pkg::WIN_BITS-1:0] window;
      logic [31:0]                   last_price;
      int unsigned                   item_count;
      logic [63:0]                   gain_avg;
      logic [63:0]                   loss_avg;
      rsi_result_type                pending[$];
      int                            mismatches;
      int                            checked;
      int                            smoothed;

      function void reset_state();
         window = 8'd14;
         last_price = '0;
         item_count = 0;
         gain_avg = '0;
         loss_avg = '0;
         pending.delete();
         mismatches = 0;
         checked = 0;
         smoothed = 0;
      endfunction

      function logic [wrsi_pkg::RSI_BITS-1:0] strength(logic [63:0] g, logic [63:0] l);
         logic [63:0] q;
         if (l == 0) return wrsi_pkg::RSI_FULL;
         while ((g + l) >= (64'd1 << wrsi_pkg::SUM_LIMIT_BIT)) begin
            g = g >> 1;
            l = l >> 1;
         end
         q = (g * 64'(wrsi_pkg::RSI_FULL)) / (g + l);
         if (q > 64'(wrsi_pkg::RSI_FULL)) q = 64'(wrsi_pkg::RSI_FULL);
         return q[wrsi_pkg::RSI_BITS-1:0];
      endfunction

      function void note_price(logic [31:0] price, bit start);
         logic [63:0]      w, up, down;
         wrsi_pkg::op_type kind;
         rsi_result_type   res;
         w = (window == 0) ? 64'd1 : 64'(window);
         up = '0;
         down = '0;
         res.rsi_value = wrsi_pkg::RSI_HALF;
         res.warming_up = 1'b1;
         if (start || item_count == 0) kind = wrsi_pkg::OP_RESTART;
         else if (item_count <= w) kind = wrsi_pkg::OP_WARM;
         else kind = wrsi_pkg::OP_SMOOTH;
         if (kind != wrsi_pkg::OP_RESTART) begin
            if (price > last_price) up = 64'(price - last_price);
            else down = 64'(last_price - price);
         end
         last_price = price;
         case (kind)
            wrsi_pkg::OP_RESTART: begin
               gain_avg = '0;
               loss_avg = '0;
               item_count = 1;
            end
            wrsi_pkg::OP_WARM: begin
               gain_avg = (gain_avg + up) & ((64'd1 << wrsi_pkg::AVG_BITS) - 1);
               loss_avg = (loss_avg + down) & ((64'd1 << wrsi_pkg::AVG_BITS) - 1);
               if (item_count == w) begin
                  gain_avg = gain_avg / w;
                  loss_avg = loss_avg / w;
               end
               item_count++;
            end
            default: begin
               gain_avg = ((gain_avg * (w - 1) + up) / w)
                          & ((64'd1 << wrsi_pkg::AVG_BITS) - 1);
               loss_avg = ((loss_avg * (w - 1) + down) / w)
                          & ((64'd1 << wrsi_pkg::AVG_BITS) - 1);
               res.rsi_value = strength(gain_avg, loss_avg);
               res.warming_up = 1'b0;
               item_count = int'(w) + 1;
               smoothed++;
            end
         endcase
         pending.push_back(res);
      endfunction

      function void check_rsi(rsi_result_type got);
         rsi_result_type want;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result rsi=%0d warm=%0b", $realtime,
                        got.rsi_value, got.warming_up);
            return;
         end
         want = pending.pop_front();
         if (got.rsi_value !== want.rsi_value || got.warming_up !== want.warming_up) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result %0d expected rsi=%0d warm=%0b, got rsi=%0d warm=%0b",
                        $realtime, checked, want.rsi_value, want.warming_up,
                        got.rsi_value, got.warming_up);
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wrsi_if #(.WIDTH(33))                 req (clock);
   wrsi_if #(.WIDTH(16))                 rsp (clock);
   wrsi_if #(.WIDTH(wrsi_pkg::WIN_BITS)) csr (clock);

   wilder_rsi_stream DUT (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   rsi_scoreboard rsi_board = new();
   int idle_mode = 0;
   int sent = 0;
   int quiet_cycles = 0;
   int windows_used = 0;

   always #6 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      csr.valid = 1'b0;
      csr.data = '0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      case (idle_mode)
         0: rsp.ready <= ($urandom_range(99) >= 73);
         1: rsp.ready <= ($urandom_range(99) >= 12);
         default: rsp.ready <= 1'b1;
      endcase
      if (!reset && rsp.valid && rsp.ready) rsi_board.check_rsi(rsi_result_type'(rsp.data));
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_price(input logic [31:0] price, input bit start);
      int idle_pct;
      idle_pct = (idle_mode == 0) ? 12 : (idle_mode == 1) ? 73 : 0;
      if ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= {price, start};
      do @(posedge clock); while (!req.ready);
      rsi_board.note_price(price, start);
      sent++;
      if (sent == 300) idle_mode = 1;
      if (sent == 600) idle_mode = 2;
   endtask

   task automatic write_window(input logic [wrsi_pkg::WIN_BITS-1:0] w);
      req.valid <= 1'b0;
      while (rsi_board.pending.size() != 0) @(posedge clock);
      repeat (160) @(posedge clock);
      csr.valid <= 1'b1;
      csr.data <= w;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      rsi_board.window = w;
      windows_used++;
   endtask

   task automatic run_series(input int len, input int step_max);
      logic [31:0] price;
      price = $urandom;
      send_price(price, 1'b1);
      for (int i = 1; i < len; i++) begin
         case ($urandom_range(9))
            0: price = $urandom;
            1: price = price;
            default: begin
               if ($urandom_range(1)) price = price + $urandom_range(step_max);
               else price = price - $urandom_range(step_max);
            end
         endcase
         send_price(price, ($urandom_range(99) == 0));
      end
   endtask

   initial begin
      logic [wrsi_pkg::WIN_BITS-1:0] w;
      int goal;
      int len;
      rsi_board.reset_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_window(8'd3);
      send_price(32'd0, 1'b0);
      send_price(32'd100, 1'b0);
      send_price(32'd200, 1'b0);
      send_price(32'd300, 1'b0);
      send_price(32'hFFFF_FFFF, 1'b0);
      send_price(32'd0, 1'b0);
      send_price(32'hFFFF_FFFF, 1'b0);
      send_price(32'h0001_0000, 1'b1);
      send_price(32'h0001_0000, 1'b0);
      send_price(32'h0001_0000, 1'b0);
      send_price(32'h0001_0000, 1'b0);
      send_price(32'h0001_0000, 1'b0);
      send_price(32'h0000_8000, 1'b0);
      send_price(32'hAAAA_5555, 1'b1);
      send_price(32'h5555_AAAA, 1'b0);
      send_price(32'h5555_AAAB, 1'b0);
      write_window(8'd1);
      send_price(32'h5555_AAAC, 1'b0);
      send_price(32'h5555_0000, 1'b0);
      write_window(8'd0);
      send_price(32'h0000_0001, 1'b1);
      send_price(32'h8000_0000, 1'b0);
      send_price(32'h7FFF_FFFF, 1'b0);

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: w = 8'd255;
            1: w = 8'd14;
            2: w = 8'd1;
            3: w = 8'd2;
            4: w = 8'd7;
            5: w = 8'd0;
            default: w = 8'($urandom_range(3, 40));
         endcase
         write_window(w);
         goal = sent + ((w == 8'd255) ? 300 : 100);
         while (sent < goal) begin
            len = $urandom_range(1, 3 * int'(w) + 12);
            if (len > goal - sent) len = goal - sent;
            run_series(len, ($urandom_range(3) == 0) ? 32'h0100_0000 : 32'h0004_0000);
         end
      end

      req.valid <= 1'b0;
      while (rsi_board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d prices over %0d window settings; %0d results checked.",
               sent, windows_used, rsi_board.checked);
      $display("Smoothed results: %0d, mismatches: %0d.", rsi_board.smoothed,
               rsi_board.mismatches);
      if (rsi_board.mismatches == 0 && rsi_board.pending.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

### wilder_rsi_stream.f
hdl/wrsi_pkg.sv
hdl/wrsi_if.sv
hdl/wrsi_front.sv
hdl/wrsi_back.sv
hdl/wilder_rsi_stream.sv
sim/wilder_rsi_stream_tb.sv
